// ===== hdl/cpu_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu_pkg
// Shared types, register indexes, angle constants and the arctangent table
// for the cylinder point unroll block.
// ----------------------------------------------------------------------------
package cpu_pkg;

    // Default number of rotation steps and the hard ceiling on the chain
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_MAX       = 32;

    // Rotation datapath widths
    localparam int CW = 62;
    localparam int ZW = 27;

    // Angles in 2^-16 degree
    localparam logic signed [ZW-1:0] DEG180 = 27'sd11796480;
    localparam logic signed [ZW-1:0] DEG360 = 27'sd23592960;

    // Input word
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               first_point;
    } cpu_in_t;

    // Result word
    typedef struct packed {
        logic signed [31:0] axial_pos;
        logic signed [31:0] radial_dev;
        logic signed [31:0] angle;
        logic               on_axis;
    } cpu_out_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CENTER_X         = 3'd0,
        REG_CENTER_Y         = 3'd1,
        REG_CENTER_Z         = 3'd2,
        REG_AXIS_VECTOR      = 3'd3,
        REG_REFERENCE_VECTOR = 3'd4,
        REG_TUBE_RADIUS      = 3'd5,
        REG_UNWRAP_ENABLE    = 3'd6
    } cpu_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DOT,
        S_PROJ,
        S_SCALE,
        S_SQ,
        S_LOAD,
        S_NORM,
        S_WAIT_DONE
    } cpu_state_t;

    // Vector handed from cell to cell
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cpu_vec_t;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_deg(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = 27'sd2949120;
            1:       v = 27'sd1740967;
            2:       v = 27'sd919879;
            3:       v = 27'sd466945;
            4:       v = 27'sd234379;
            5:       v = 27'sd117304;
            6:       v = 27'sd58666;
            7:       v = 27'sd29335;
            8:       v = 27'sd14668;
            9:       v = 27'sd7334;
            10:      v = 27'sd3667;
            11:      v = 27'sd1833;
            12:      v = 27'sd917;
            13:      v = 27'sd458;
            14:      v = 27'sd229;
            15:      v = 27'sd115;
            16:      v = 27'sd57;
            17:      v = 27'sd29;
            18:      v = 27'sd14;
            19:      v = 27'sd7;
            20:      v = 27'sd4;
            21:      v = 27'sd2;
            22:      v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/cpu_cell.sv =====
// ----------------------------------------------------------------------------
// cpu_cell
// One vectoring rotation step: rotates toward the x axis by atan(2^-STEP)
// and registers the result for the next cell.
// ----------------------------------------------------------------------------
module cpu_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vin,
    input  cpu_pkg::cpu_vec_t din,
    output logic              vout,
    output cpu_pkg::cpu_vec_t dout
);
    import cpu_pkg::*;

    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    cpu_vec_t             vec_next;
    cpu_vec_t             vec_reg;
    logic                 valid_reg;

    // Rotate by the sign of y; leave the vector alone when y is zero
    always_comb
    begin
        x_in     = din.x;
        y_in     = din.y;
        dx       = y_in >>> STEP;
        dy       = x_in >>> STEP;
        vec_next = din;
        if (y_in > 0)
        begin
            vec_next.x = x_in + dx;
            vec_next.y = y_in - dy;
            vec_next.z = din.z + atan_deg(STEP);
        end
        else if (y_in < 0)
        begin
            vec_next.x = x_in - dx;
            vec_next.y = y_in + dy;
            vec_next.z = din.z - atan_deg(STEP);
        end
    end

    // Hold valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= vin;
        end
    end

    // Advance the vector
    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign vout = valid_reg;
    assign dout = vec_reg;

endmodule

// ===== hdl/cpu_sqrt.sv =====
// ----------------------------------------------------------------------------
// cpu_sqrt
// Iterative square root of a 64-bit value, one result bit per cycle,
// rounded to nearest at the end.
// ----------------------------------------------------------------------------
module cpu_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [32:0] root
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    // One digit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        if (start)
        begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[63:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    // Round up when the remainder exceeds the root
    assign done = done_reg;
    assign root = {1'b0, res_reg[31:0]} + ((rem_reg > res_reg) ? 33'd1 : 33'd0);

endmodule

// ===== hdl/cylinder_point_unroll.sv =====
// ----------------------------------------------------------------------------
// cylinder_point_unroll
// Maps one 3D point per word onto a cylinder: axial position, radial
// deviation from the nominal radius, and angle around the axis, optionally
// unwrapped across a run of points.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid / in_ready        cpu_in_t  in_data
//   out      output     out_valid / out_ready      cpu_out_t out_data
//   cfg      input      cfg_wr_en                  cfg_index, cfg_data
//
// A result is registered once both the square root unit and the rotation chain
// have finished and the output register is free. Ahead of them the sequencer
// runs three multiply passes over the three axes (dot product, projection, then
// squares and products), with a scaling step after the projection that shifts
// the radial vector down as far as the largest points need, and a load step
// that starts the 32-step square root. The rotation chain of CORDIC_STEPS cells
// (capped at CORDIC_MAX) runs alongside the square root once its input is
// normalized. A new word is taken only once the previous result sits in the
// output register, so words do not overlap; a stalled output holds the sequencer
// at its last step. Reset clears all control state and loads the register reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cylinder_point_unroll #(
    parameter int CORDIC_STEPS = cpu_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cpu_pkg::cpu_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cpu_pkg::cpu_out_t out_data,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [47:0]       cfg_data
);
    import cpu_pkg::*;

    localparam int NCELL = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;

    // Configuration
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [47:0]        axis_reg, ref_reg;
    logic [30:0]        rad_reg;
    logic               unwrap_reg;

    // Sequencer and datapath
    cpu_state_t         state_reg, state_next;
    logic [1:0]         k_reg, k_next;
    logic [5:0]         s_reg, s_next;
    logic               first_reg, first_next;
    logic signed [32:0] d_reg [0:2];
    logic signed [32:0] d_next [0:2];
    logic signed [50:0] yq_reg, yq_next;
    logic signed [19:0] p_reg [0:2];
    logic signed [19:0] p_next [0:2];
    logic signed [40:0] r_reg [0:2];
    logic signed [40:0] r_next [0:2];
    logic [63:0]        sum_reg, sum_next;
    logic signed [55:0] cs_reg, cs_next;
    logic signed [55:0] sn_reg, sn_next;
    logic signed [CW-1:0] xn_reg, xn_next;
    logic signed [CW-1:0] yn_reg, yn_next;
    logic               axis0_reg, axis0_next;
    logic               sq_got_reg, sq_got_next;
    logic               cor_got_reg, cor_got_next;
    logic [32:0]        root_reg, root_next;
    logic [24:0]        raw_reg, raw_next;

    // Run state
    logic [24:0]        prev_reg, prev_next;
    logic signed [31:0] uw_reg, uw_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    cpu_out_t           out_reg, out_next;

    // Shared unit handshakes
    logic               sqrt_start, sqrt_done;
    logic [32:0]        sqrt_root;
    logic               head_v;
    cpu_vec_t           head_d;
    logic               chain_v [0:NCELL];
    cpu_vec_t           chain_d [0:NCELL];

    // Working values
    logic signed [15:0] ak, rvk, pa, pb, pc, pd;
    logic signed [48:0] dot_prod;
    logic signed [31:0] pp1, pp2;
    logic signed [33:0] pdiff;
    logic signed [36:0] yr;
    logic signed [52:0] proj;
    logic [40:0]        ur [0:2];
    logic [40:0]        ush;
    logic [30:0]        u;
    logic [61:0]        usq;
    logic signed [31:0] rs;
    logic signed [47:0] cprod;
    logic signed [51:0] sprod;
    logic               big;
    logic [CW-1:0]      ax, ay, m;
    logic signed [ZW-1:0] zw;
    logic signed [26:0] diff;
    logic signed [32:0] acc;
    logic signed [31:0] uw_new;
    logic [73:0]        mag;
    logic signed [74:0] dev_w;
    logic signed [31:0] dev;
    logic signed [31:0] axial;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            axis_reg   <= 48'h4000_0000_0000;
            ref_reg    <= 48'h0000_C000_0000;
            rad_reg    <= '0;
            unwrap_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cpu_reg_t'(cfg_index))
                REG_CENTER_X:         cx_reg     <= cfg_data[31:0];
                REG_CENTER_Y:         cy_reg     <= cfg_data[31:0];
                REG_CENTER_Z:         cz_reg     <= cfg_data[31:0];
                REG_AXIS_VECTOR:      axis_reg   <= cfg_data;
                REG_REFERENCE_VECTOR: ref_reg    <= cfg_data;
                REG_TUBE_RADIUS:      rad_reg    <= cfg_data[30:0];
                REG_UNWRAP_ENABLE:    unwrap_reg <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // Square root unit
    cpu_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Rotation chain
    assign chain_v[0] = head_v;
    assign chain_d[0] = head_d;

    generate
        for (genvar g = 0; g < NCELL; g++)
        begin : g_cell
            cpu_cell #(
                .STEP (g)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .vin   (chain_v[g]),
                .din   (chain_d[g]),
                .vout  (chain_v[g+1]),
                .dout  (chain_d[g+1])
            );
        end
    endgenerate

    // Per-index selections and fixed arithmetic
    always_comb
    begin
        ak  = axis_reg[16*k_reg +: 16];
        rvk = ref_reg[16*k_reg +: 16];
        case (k_reg)
            2'd0:
            begin
                pa = axis_reg[31:16]; pb = ref_reg[47:32];
                pc = axis_reg[47:32]; pd = ref_reg[31:16];
            end
            2'd1:
            begin
                pa = axis_reg[47:32]; pb = ref_reg[15:0];
                pc = axis_reg[15:0];  pd = ref_reg[47:32];
            end
            default:
            begin
                pa = axis_reg[15:0];  pb = ref_reg[31:16];
                pc = axis_reg[31:16]; pd = ref_reg[15:0];
            end
        endcase
        dot_prod = d_reg[k_reg] * ak;
        pp1      = pa * pb;
        pp2      = pc * pd;
        pdiff    = 34'(pp1) - 34'(pp2) + 34'sd8192;
        yr       = 37'((yq_reg + 51'sd8192) >>> 14);
        proj     = (53'(ak) * 53'(yr) + 53'sd8192) >>> 14;
        for (int i = 0; i < 3; i++)
        begin
            ur[i] = r_reg[i][40] ? 41'(-r_reg[i]) : 41'(r_reg[i]);
        end
        big = ((ur[0] >> s_reg) >= 41'h8000_0000) ||
              ((ur[1] >> s_reg) >= 41'h8000_0000) ||
              ((ur[2] >> s_reg) >= 41'h8000_0000);
        ush   = ur[k_reg] >> s_reg;
        u     = ush[30:0];
        usq   = u * u;
        rs    = r_reg[k_reg][40] ? -$signed({1'b0, u}) : $signed({1'b0, u});
        cprod = rs * rvk;
        sprod = rs * p_reg[k_reg];
        ax  = xn_reg[CW-1] ? CW'(-xn_reg) : CW'(xn_reg);
        ay  = yn_reg[CW-1] ? CW'(-yn_reg) : CW'(yn_reg);
        m   = (ax > ay) ? ax : ay;
        zw  = chain_d[NCELL].z;
        if (zw < 0)
        begin
            zw = zw + DEG360;
        end
        else if (zw >= DEG360)
        begin
            zw = zw - DEG360;
        end
    end

    // Result arithmetic: unwrap, deviation, axial saturation
    always_comb
    begin
        diff = $signed({2'b00, raw_reg}) - $signed({2'b00, prev_reg});
        if (diff > DEG180)
        begin
            diff = diff - DEG360;
        end
        else if (diff < -DEG180)
        begin
            diff = diff + DEG360;
        end
        acc = 33'(uw_reg) + 33'(diff);
        if (acc > 33'sd2147483647)
        begin
            uw_new = 32'sh7FFF_FFFF;
        end
        else if (acc < -33'sd2147483648)
        begin
            uw_new = 32'sh8000_0000;
        end
        else
        begin
            uw_new = acc[31:0];
        end
        if (first_reg)
        begin
            uw_new = $signed({7'd0, raw_reg});
        end
        mag   = {41'd0, root_reg} << s_reg;
        dev_w = $signed({1'b0, mag}) - $signed({44'd0, rad_reg});
        dev   = (dev_w > 75'sd2147483647) ? 32'sh7FFF_FFFF : dev_w[31:0];
        if (yr > 37'sd2147483647)
        begin
            axial = 32'sh7FFF_FFFF;
        end
        else if (yr < -37'sd2147483648)
        begin
            axial = 32'sh8000_0000;
        end
        else
        begin
            axial = yr[31:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        first_next     = first_reg;
        d_next         = d_reg;
        yq_next        = yq_reg;
        p_next         = p_reg;
        r_next         = r_reg;
        sum_next       = sum_reg;
        cs_next        = cs_reg;
        sn_next        = sn_reg;
        xn_next        = xn_reg;
        yn_next        = yn_reg;
        axis0_next     = axis0_reg;
        sq_got_next    = sq_got_reg;
        cor_got_next   = cor_got_reg;
        root_next      = root_reg;
        raw_next       = raw_reg;
        prev_next      = prev_reg;
        uw_next        = uw_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        sqrt_start     = 1'b0;
        head_v         = 1'b0;
        head_d.x       = xn_reg;
        head_d.y       = yn_reg;
        head_d.z       = '0;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    d_next[0]  = 33'(in_data.pos_x) - 33'(cx_reg);
                    d_next[1]  = 33'(in_data.pos_y) - 33'(cy_reg);
                    d_next[2]  = 33'(in_data.pos_z) - 33'(cz_reg);
                    first_next = in_data.first_point;
                    yq_next    = '0;
                    k_next     = '0;
                    state_next = S_DOT;
                end
            end
            S_DOT:
            begin
                yq_next       = yq_reg + 51'(dot_prod);
                p_next[k_reg] = 20'(pdiff >>> 14);
                if (k_reg == 2'd2)
                begin
                    k_next     = '0;
                    state_next = S_PROJ;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_PROJ:
            begin
                r_next[k_reg] = 41'(d_reg[k_reg]) - 41'(proj);
                if (k_reg == 2'd2)
                begin
                    k_next     = '0;
                    s_next     = '0;
                    state_next = S_SCALE;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_SCALE:
            begin
                if (big && (s_reg < 6'd40))
                begin
                    s_next = s_reg + 6'd1;
                end
                else
                begin
                    k_next     = '0;
                    sum_next   = '0;
                    cs_next    = '0;
                    sn_next    = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                sum_next = sum_reg + 64'(usq);
                cs_next  = cs_reg + 56'(cprod);
                sn_next  = sn_reg + 56'(sprod);
                if (k_reg == 2'd2)
                begin
                    k_next     = '0;
                    state_next = S_LOAD;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_LOAD:
            begin
                sqrt_start   = 1'b1;
                xn_next      = CW'(cs_reg);
                yn_next      = CW'(sn_reg);
                axis0_next   = (r_reg[0] == 0) && (r_reg[1] == 0) && (r_reg[2] == 0);
                sq_got_next  = 1'b0;
                cor_got_next = 1'b0;
                state_next   = S_NORM;
            end
            S_NORM:
            begin
                if (axis0_reg || (m == '0))
                begin
                    raw_next     = '0;
                    cor_got_next = 1'b1;
                    state_next   = S_WAIT_DONE;
                end
                else if (m[CW-1:48] == '0)
                begin
                    xn_next = xn_reg <<< 8;
                    yn_next = yn_reg <<< 8;
                end
                else if (m[CW-1:56] == '0)
                begin
                    xn_next = xn_reg <<< 1;
                    yn_next = yn_reg <<< 1;
                end
                else
                begin
                    // Pre-rotate by half a turn for the left half-plane
                    head_v = 1'b1;
                    if (xn_reg < 0)
                    begin
                        head_d.x = -xn_reg;
                        head_d.y = -yn_reg;
                        head_d.z = DEG180;
                    end
                    state_next = S_WAIT_DONE;
                end
            end
            S_WAIT_DONE:
            begin
                if (sq_got_reg && cor_got_reg && (!out_valid_reg || out_ready))
                begin
                    out_next.axial_pos  = axial;
                    out_next.radial_dev = dev;
                    out_next.angle      = unwrap_reg ? uw_new : $signed({7'd0, raw_reg});
                    out_next.on_axis    = axis0_reg;
                    out_valid_next      = 1'b1;
                    uw_next             = uw_new;
                    prev_next           = raw_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Catch finished shared units
        if (sqrt_done)
        begin
            root_next   = sqrt_root;
            sq_got_next = 1'b1;
        end
        if (chain_v[NCELL])
        begin
            raw_next     = zw[24:0];
            cor_got_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            s_reg         <= '0;
            sq_got_reg    <= 1'b0;
            cor_got_reg   <= 1'b0;
            prev_reg      <= '0;
            uw_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            s_reg         <= s_next;
            sq_got_reg    <= sq_got_next;
            cor_got_reg   <= cor_got_next;
            prev_reg      <= prev_next;
            uw_reg        <= uw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        d_reg     <= d_next;
        yq_reg    <= yq_next;
        p_reg     <= p_next;
        r_reg     <= r_next;
        sum_reg   <= sum_next;
        cs_reg    <= cs_next;
        sn_reg    <= sn_next;
        xn_reg    <= xn_next;
        yn_reg    <= yn_next;
        axis0_reg <= axis0_next;
        root_reg  <= root_next;
        raw_reg   <= raw_next;
        out_reg   <= out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
